FILE: rtl/core/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types and constants of the frame segment classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsc_pkg;

  localparam int FRAME_BITS    = 24;
  localparam int OFFSET_BITS   = 24;
  localparam int RANGE_BITS    = 25;
  // effective frame: frame minus signed offset, exact
  localparam int EFF_BITS      = 26;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 25;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BLANK = 2'd1,
    CMD_PAIR  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef logic [1:0] verdict_t;

  // blank query classes
  localparam verdict_t V_BLANK        = 2'd0;
  localparam verdict_t V_STATIC       = 2'd1;
  localparam verdict_t V_ANIMATED     = 2'd2;
  // pair query verdicts
  localparam verdict_t V_IDENTICAL    = 2'd0;
  localparam verdict_t V_DIFFERENT    = 2'd1;
  localparam verdict_t V_UNDETERMINED = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_OFFSET = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE_FROM   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RANGE_TO     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_DONE   = 2'd2
  } fsm_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [FRAME_BITS-1:0] seg_begin;
    logic [FRAME_BITS-1:0] seg_end;
    logic                  seg_animated;
    logic [FRAME_BITS-1:0] frame_a;
    logic [FRAME_BITS-1:0] frame_b;
  } in_t;

  typedef struct packed {
    verdict_t verdict;
    logic     table_full;
  } out_t;

endpackage

`default_nettype wire

FILE: rtl/core/fsc_ram.sv
// ----------------------------------------------------------------------------
// fsc_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

FILE: rtl/core/fsc_search_cell.sv
// ----------------------------------------------------------------------------
// fsc_search_cell
// One halving step of the segment search; registers the updated token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsc_search_cell #(
  parameter int AW = 10,
  parameter int CW = 11
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                vld_i,
  input  wire logic        [CW-1:0]                first_i,
  input  wire logic        [CW-1:0]                count_i,
  input  wire logic        [fsc_pkg::FRAME_BITS-1:0] end_i,
  input  wire logic signed [fsc_pkg::EFF_BITS-1:0] frame_i,
  output logic                                     vld_o,
  output logic             [CW-1:0]                first_o,
  output logic             [CW-1:0]                count_o,
  output logic             [AW-1:0]                addr_o
);

  import fsc_pkg::*;

  logic          vld_r;
  logic [CW-1:0] first_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] first_nxt;
  logic [CW-1:0] count_nxt;
  logic [CW-1:0] step;
  logic [CW-1:0] probe;
  logic [CW-1:0] next_probe;
  logic          take;

  // end_i is end[probe] of the incoming token, read in the cycle before
  always_comb begin
    step       = count_i >> 1;
    probe      = first_i + step;
    take       = $signed({{(EFF_BITS-FRAME_BITS){1'b0}}, end_i}) <= frame_i;
    first_nxt  = first_i;
    count_nxt  = count_i;
    if (count_i != '0) begin
      if (take) begin
        first_nxt = probe + CW'(1);
        count_nxt = count_i - step - CW'(1);
      end else begin
        count_nxt = step;
      end
    end
    next_probe = first_nxt + (count_nxt >> 1);
    addr_o     = vld_i ? next_probe[AW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_i) begin
      first_r <= first_nxt;
      count_r <= count_nxt;
    end
  end

  assign vld_o   = vld_r;
  assign first_o = first_r;
  assign count_o = count_r;

endmodule

`default_nettype wire

FILE: rtl/core/frame_segment_classifier.sv
// ----------------------------------------------------------------------------
// frame_segment_classifier
// Segment table with blank and pair-identity frame queries.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready request channel carrying one command (load, blank
//           query, pair query, clear). One request is worked on at a time.
//   out_* : valid/ready result channel, exactly one result per request,
//           held in an output register until taken.
//   cfg_* : plain write port for offset and active range, written when idle.
// Request flow:
//   load / clear : no search; the result register is loaded on acceptance.
//   queries      : the search runs through a row of $clog2(MAX_SEGMENTS+1)
//                  cells, one per halving step, each fed by a registered
//                  read of the end RAM; a further registered read of the
//                  begin RAM fetches begin/flag at the found entry. Both
//                  frames of a pair go down two lanes at once on the RAMs'
//                  two read ports.
// Reset: table empty, offset 0, range registers -1 (table defaults).
// A new request is accepted while a result waits in the output register;
// its own result holds inside until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module frame_segment_classifier #(
  parameter int MAX_SEGMENTS = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire fsc_pkg::in_t                       in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output fsc_pkg::out_t                           out_data,
  input  wire logic                               cfg_we,
  input  wire logic [fsc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [fsc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  import fsc_pkg::*;

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int NSTEP = CW;

  // configuration
  logic        [OFFSET_BITS-1:0] offset_r;
  logic        [RANGE_BITS-1:0]  range_from_r;
  logic        [RANGE_BITS-1:0]  range_to_r;

  // table bookkeeping
  logic        [CW-1:0]          seg_count_r;
  logic        [FRAME_BITS-1:0]  begin0_r;
  logic        [FRAME_BITS-1:0]  last_end_r;
  logic                          table_is_full;

  // control
  fsm_t                          state_r;
  fsm_t                          state_nxt;
  logic                          accept;
  logic                          start_q;
  logic                          start_r;
  logic                          fin_r;
  logic                          res_take;
  cmd_t                          cmd_r;
  logic                          ia_r;
  logic                          ib_r;
  logic signed [EFF_BITS-1:0]    f_a_r;
  logic signed [EFF_BITS-1:0]    f_b_r;
  logic signed [EFF_BITS-1:0]    eff_a;
  logic signed [EFF_BITS-1:0]    eff_b;
  out_t                          res_r;
  out_t                          res_nxt;
  logic                          res_load;
  logic                          out_valid_r;
  out_t                          out_data_r;

  // search lanes: 0 for frame_a, 1 for frame_b
  logic        [NSTEP:0]         stg_vld   [2];
  logic        [CW-1:0]          stg_first [2][NSTEP+1];
  logic        [CW-1:0]          stg_count [2][NSTEP+1];
  logic        [AW-1:0]          cell_addr [2][NSTEP];
  logic        [AW-1:0]          end_raddr [2];
  logic        [AW-1:0]          beg_raddr [2];
  logic        [FRAME_BITS-1:0]  end_rd    [2];
  logic        [FRAME_BITS:0]    beg_rd    [2];
  logic signed [EFF_BITS-1:0]    lane_f    [2];
  verdict_t                      cls       [2];
  logic                          ram_we;

  function automatic logic signed [EFF_BITS-1:0] eff_frame(
    input logic [FRAME_BITS-1:0]  frame,
    input logic [OFFSET_BITS-1:0] offs
  );
    eff_frame = $signed({{(EFF_BITS-FRAME_BITS){1'b0}}, frame})
              - $signed({{(EFF_BITS-OFFSET_BITS){offs[OFFSET_BITS-1]}}, offs});
  endfunction

  function automatic logic in_active(
    input logic signed [EFF_BITS-1:0]   f,
    input logic        [RANGE_BITS-1:0] rf,
    input logic        [RANGE_BITS-1:0] rt,
    input logic                         empty,
    input logic        [FRAME_BITS-1:0] b0,
    input logic        [FRAME_BITS-1:0] le
  );
    logic signed [EFF_BITS-1:0] lo;
    logic signed [EFF_BITS-1:0] hi;
    lo = $signed({{(EFF_BITS-RANGE_BITS){rf[RANGE_BITS-1]}}, rf});
    hi = $signed({{(EFF_BITS-RANGE_BITS){rt[RANGE_BITS-1]}}, rt});
    // -1 selects the table default
    if (rf == '1) begin
      lo = empty ? '1 : $signed({{(EFF_BITS-FRAME_BITS){1'b0}}, b0});
    end
    if (rt == '1) begin
      hi = empty ? '1 : $signed({{(EFF_BITS-FRAME_BITS){1'b0}}, le});
    end
    in_active = !(f < lo || f >= hi);
  endfunction

  assign accept        = in_valid && in_ready;
  assign table_is_full = (seg_count_r == CW'(MAX_SEGMENTS));
  assign eff_a         = eff_frame(in_data.frame_a, offset_r);
  assign eff_b         = eff_frame(in_data.frame_b, offset_r);
  assign ram_we        = accept && (in_data.cmd == CMD_LOAD) && !table_is_full;

  // ---------------------------------------------------------------- FSM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    start_q   = 1'b0;
    res_load  = 1'b0;
    res_take  = 1'b0;
    res_nxt   = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_data.cmd)
            CMD_LOAD: begin
              res_load           = 1'b1;
              res_nxt.table_full = table_is_full;
              state_nxt          = ST_DONE;
            end
            CMD_CLEAR: begin
              res_load  = 1'b1;
              state_nxt = ST_DONE;
            end
            CMD_BLANK, CMD_PAIR: begin
              start_q   = 1'b1;
              state_nxt = ST_SEARCH;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (fin_r) begin
          res_load = 1'b1;
          if (cmd_r == CMD_BLANK) begin
            res_nxt.verdict = ia_r ? cls[0] : V_BLANK;
          end else if (!ia_r) begin
            res_nxt.verdict = ib_r ? cls[1] : V_IDENTICAL;
          end else if (!ib_r) begin
            res_nxt.verdict = cls[0];
          end else if (cls[0] == V_BLANK && cls[1] == V_BLANK) begin
            res_nxt.verdict = V_IDENTICAL;
          end else if ((cls[0] == V_BLANK && cls[1] == V_STATIC) ||
                       (cls[0] == V_STATIC && cls[1] == V_BLANK)) begin
            res_nxt.verdict = V_DIFFERENT;
          end else if (cls[0] == V_STATIC && cls[1] == V_STATIC &&
                       stg_first[0][NSTEP] == stg_first[1][NSTEP]) begin
            res_nxt.verdict = V_IDENTICAL;
          end else begin
            res_nxt.verdict = V_UNDETERMINED;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          res_take  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------ control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r     <= '0;
      range_from_r <= '1;
      range_to_r   <= '1;
      seg_count_r  <= '0;
      start_r      <= 1'b0;
      fin_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_OFFSET: offset_r     <= cfg_wdata[OFFSET_BITS-1:0];
          CFG_RANGE_FROM:   range_from_r <= cfg_wdata[RANGE_BITS-1:0];
          CFG_RANGE_TO:     range_to_r   <= cfg_wdata[RANGE_BITS-1:0];
          default: ;
        endcase
      end
      if (ram_we) begin
        seg_count_r <= seg_count_r + CW'(1);
      end else if (accept && in_data.cmd == CMD_CLEAR) begin
        seg_count_r <= '0;
      end
      start_r <= start_q;
      fin_r   <= stg_vld[0][NSTEP];
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------ payload registers
  always_ff @(posedge clk) begin
    if (ram_we) begin
      last_end_r <= in_data.seg_end;
      if (seg_count_r == '0) begin
        begin0_r <= in_data.seg_begin;
      end
    end
    if (start_q) begin
      cmd_r <= in_data.cmd;
      f_a_r <= eff_a;
      f_b_r <= eff_b;
      ia_r  <= in_active(eff_a, range_from_r, range_to_r, seg_count_r == '0,
                         begin0_r, last_end_r);
      ib_r  <= in_active(eff_b, range_from_r, range_to_r, seg_count_r == '0,
                         begin0_r, last_end_r);
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
    if (res_take) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ------------------------------------------------------------- memories
  fsc_ram #(
    .WIDTH (FRAME_BITS),
    .DEPTH (MAX_SEGMENTS)
  ) u_end_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (seg_count_r[AW-1:0]),
    .wdata   (in_data.seg_end),
    .raddr_a (end_raddr[0]),
    .raddr_b (end_raddr[1]),
    .rdata_a (end_rd[0]),
    .rdata_b (end_rd[1])
  );

  // {animated, begin}
  fsc_ram #(
    .WIDTH (FRAME_BITS + 1),
    .DEPTH (MAX_SEGMENTS)
  ) u_begin_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (seg_count_r[AW-1:0]),
    .wdata   ({in_data.seg_animated, in_data.seg_begin}),
    .raddr_a (beg_raddr[0]),
    .raddr_b (beg_raddr[1]),
    .rdata_a (beg_rd[0]),
    .rdata_b (beg_rd[1])
  );

  // ---------------------------------------------------------- search lanes
  assign lane_f[0] = f_a_r;
  assign lane_f[1] = f_b_r;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [CW-1:0] half_count;

    assign stg_vld[l][0]   = start_r;
    assign stg_first[l][0] = '0;
    assign stg_count[l][0] = seg_count_r;
    assign half_count      = seg_count_r >> 1;

    for (genvar c = 0; c < NSTEP; c++) begin : g_cell
      fsc_search_cell #(
        .AW (AW),
        .CW (CW)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_i   (stg_vld[l][c]),
        .first_i (stg_first[l][c]),
        .count_i (stg_count[l][c]),
        .end_i   (end_rd[l]),
        .frame_i (lane_f[l]),
        .vld_o   (stg_vld[l][c+1]),
        .first_o (stg_first[l][c+1]),
        .count_o (stg_count[l][c+1]),
        .addr_o  (cell_addr[l][c])
      );
    end

    // first probe goes out with the request; later ones come from the
    // cell holding the token
    always_comb begin
      end_raddr[l] = start_q ? half_count[AW-1:0] : '0;
      for (int c = 0; c < NSTEP; c++) begin
        end_raddr[l] = end_raddr[l] | cell_addr[l][c];
      end
    end

    assign beg_raddr[l] = stg_first[l][NSTEP][AW-1:0];

    // past-end guard works on the full-width index
    always_comb begin
      if (stg_first[l][NSTEP] >= seg_count_r ||
          $signed({{(EFF_BITS-FRAME_BITS){1'b0}}, beg_rd[l][FRAME_BITS-1:0]})
            > lane_f[l]) begin
        cls[l] = V_BLANK;
      end else if (beg_rd[l][FRAME_BITS]) begin
        cls[l] = V_ANIMATED;
      end else begin
        cls[l] = V_STATIC;
      end
    end
  end

  // ------------------------------------------------------------ assertions
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(stg_vld[0]))
    else $error("more than one search token in flight");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld[0] == stg_vld[1])
    else $error("search lanes out of step");

  a_token_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (|stg_vld[0]) |-> state_r == ST_SEARCH)
    else $error("search token outside of search state");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seg_count_r <= CW'(MAX_SEGMENTS))
    else $error("segment count beyond table size");

  a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> (stg_first[0][NSTEP] <= seg_count_r &&
               stg_first[1][NSTEP] <= seg_count_r))
    else $error("search result beyond segment count");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frame segment classifier. Builds segment
// tables through load and clear requests, sweeps the frame offset and the
// active range through their extremes and defaults, and checks every result
// against a bit-true predictor in the bench or a directed row's own want.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fsc_pkg::*;

  localparam int MAX_SEGS        = 1024;
  localparam int HOLD_CYCLES     = 300;
  localparam int RANDOM_REQUESTS = 620;
  localparam int DRAIN_CYCLES    = 20;
  localparam int PRINT_CAP       = 100;
  // index with no register behind it; writes there must be ignored
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  in_t                      in_data;
  logic                     out_valid;
  logic                     out_ready;
  out_t                     out_data;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  frame_segment_classifier #(.MAX_SEGMENTS(MAX_SEGS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: segment table and register copies
  logic [FRAME_BITS-1:0]  tbl_begin [MAX_SEGS];
  logic [FRAME_BITS-1:0]  tbl_end   [MAX_SEGS];
  logic                   tbl_anim  [MAX_SEGS];
  int unsigned            tbl_count;
  logic [OFFSET_BITS-1:0] m_offset;
  logic [RANGE_BITS-1:0]  m_from;
  logic [RANGE_BITS-1:0]  m_to;

  out_t verdict_q[$];

  // segments of the current episode, used to aim query frames
  logic [FRAME_BITS-1:0] ep_lo[$];
  logic [FRAME_BITS-1:0] ep_hi[$];

  int errors        = 0;
  int results_seen  = 0;
  int full_seen     = 0;
  int requests_sent = 0;
  int settings_used = 0;
  int in_idle_pct   = 13;
  int out_idle_pct  = 58;
  int hold_asked    = 0;
  int hold_served   = 0;

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic longint effective_frame(logic [FRAME_BITS-1:0] frame);
    return longint'(frame) - longint'($signed(m_offset));
  endfunction

  function automatic bit frame_active(longint f);
    longint lo, hi;
    lo = longint'($signed(m_from));
    hi = longint'($signed(m_to));
    // -1 falls back to the table's own span
    if (lo == -1) lo = (tbl_count != 0) ? longint'(tbl_begin[0]) : -1;
    if (hi == -1) hi = (tbl_count != 0) ? longint'(tbl_end[tbl_count-1]) : -1;
    return !(f < lo || f >= hi);
  endfunction

  function automatic verdict_t segment_class(longint f, output int unsigned idx);
    int unsigned first, span, half, probe;
    first = 0;
    span  = tbl_count;
    while (span > 0) begin
      half  = span / 2;
      probe = first + half;
      if (longint'(tbl_end[probe]) <= f) begin
        first = probe + 1;
        span  = span - half - 1;
      end else begin
        span = half;
      end
    end
    idx = first;
    if (first >= tbl_count || longint'(tbl_begin[first]) > f) return V_BLANK;
    return tbl_anim[first] ? V_ANIMATED : V_STATIC;
  endfunction

  function automatic out_t classify_request(in_t r);
    out_t        res;
    longint      fa, fb;
    bit          act_a, act_b;
    verdict_t    ca, cb;
    int unsigned sa, sb;
    res = '0;
    case (r.cmd)
      CMD_LOAD: begin
        if (tbl_count >= MAX_SEGS) begin
          res.table_full = 1'b1;
        end else begin
          tbl_begin[tbl_count] = r.seg_begin;
          tbl_end[tbl_count]   = r.seg_end;
          tbl_anim[tbl_count]  = r.seg_animated;
          tbl_count++;
        end
      end
      CMD_BLANK: begin
        fa = effective_frame(r.frame_a);
        res.verdict = frame_active(fa) ? segment_class(fa, sa) : V_BLANK;
      end
      CMD_PAIR: begin
        fa    = effective_frame(r.frame_a);
        fb    = effective_frame(r.frame_b);
        act_a = frame_active(fa);
        act_b = frame_active(fb);
        // one frame outside: blank/static/animated map straight onto
        // identical/different/undetermined
        if (!act_a) begin
          res.verdict = act_b ? segment_class(fb, sb) : V_IDENTICAL;
        end else if (!act_b) begin
          res.verdict = segment_class(fa, sa);
        end else begin
          ca = segment_class(fa, sa);
          cb = segment_class(fb, sb);
          if (ca == V_BLANK && cb == V_BLANK)
            res.verdict = V_IDENTICAL;
          else if ((ca == V_BLANK && cb == V_STATIC) || (ca == V_STATIC && cb == V_BLANK))
            res.verdict = V_DIFFERENT;
          else if (ca == V_STATIC && cb == V_STATIC && sa == sb)
            res.verdict = V_IDENTICAL;
          else
            res.verdict = V_UNDETERMINED;
        end
      end
      CMD_CLEAR: tbl_count = 0;
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_t random_request();
    in_t r;
    r.cmd          = cmd_t'($urandom_range(3));
    r.seg_begin    = FRAME_BITS'($urandom);
    r.seg_end      = FRAME_BITS'($urandom);
    r.seg_animated = 1'($urandom_range(1));
    r.frame_a      = FRAME_BITS'($urandom);
    r.frame_b      = FRAME_BITS'($urandom);
    return r;
  endfunction

  function automatic plan_row_t mk_row(cmd_t c, int p0, int p1, bit anim,
                                       bit typed = 0, verdict_t v = V_BLANK);
    plan_row_t row;
    row.req.cmd          = c;
    row.req.seg_begin    = FRAME_BITS'(p0);
    row.req.seg_end      = FRAME_BITS'(p1);
    row.req.seg_animated = anim;
    row.req.frame_a      = FRAME_BITS'(p0);
    row.req.frame_b      = FRAME_BITS'(p1);
    row.typed            = typed;
    row.want             = '{verdict: v, table_full: 1'b0};
    return row;
  endfunction

  task automatic add_row(input plan_row_t row);
    plan.insert(plan.size(), row);
  endtask

  // aim at segment edges and range edges, shifted back by the offset
  function automatic logic [FRAME_BITS-1:0] pick_frame();
    longint f;
    int     k;
    if (ep_lo.size() == 0 || $urandom_range(9) == 0) return FRAME_BITS'($urandom);
    k = $urandom_range(ep_lo.size() - 1);
    case ($urandom_range(6))
      0: f = ep_lo[k];
      1: f = longint'(ep_lo[k]) - 1;
      2: f = longint'(ep_hi[k]) - 1;
      3: f = ep_hi[k];
      4: f = longint'($signed(m_from));
      5: f = longint'($signed(m_to)) - longint'($urandom_range(1));
      default: f = longint'(ep_lo[k]) + longint'($urandom_range(8));
    endcase
    return FRAME_BITS'(f + longint'($signed(m_offset)));
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    // keep the log short when everything goes wrong
    if (errors < PRINT_CAP)
      $display("%0t result %0d: %s got %0d want %0d", $time, results_seen, what, got, want);
    errors++;
  endtask

  task automatic send_request(input in_t req, input bit typed = 0,
                              input out_t want = '0);
    out_t pred;
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = classify_request(req);
    verdict_q.insert(verdict_q.size(), typed ? want : pred);
    requests_sent++;
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_OFFSET: m_offset = data[OFFSET_BITS-1:0];
      CFG_RANGE_FROM:   m_from   = data;
      CFG_RANGE_TO:     m_to     = data;
      default: ;
    endcase
  endtask

  function automatic logic [RANGE_BITS-1:0] random_range_reg(bit upper);
    int k;
    k = ep_lo.size() ? $urandom_range(ep_lo.size() - 1) : 0;
    case ($urandom_range(9))
      5: return '0;
      6: return RANGE_BITS'(24'hFFFFFF);
      7: return RANGE_BITS'(-longint'($urandom_range(16777216, 2)));
      8, 9: begin
        if (ep_lo.size() == 0) return RANGE_BITS'($urandom);
        if (upper) return RANGE_BITS'(longint'(ep_hi[k]) + $urandom_range(4) - 2);
        return RANGE_BITS'(longint'(ep_lo[k]) + $urandom_range(4) - 2);
      end
      default: return '1;
    endcase
  endfunction

  task automatic run_episode(int ep);
    logic [OFFSET_BITS-1:0] off;
    logic [RANGE_BITS-1:0]  rf, rt;
    longint                 cursor, lo, hi, lower;
    int                     n_segs, n_q, sel, k;
    in_t                    r;

    case (ep)
      0:       off = 24'h800000;
      1:       off = 24'h7FFFFF;
      2:       off = '0;
      default: begin
        case ($urandom_range(4))
          0: off = '0;
          1: off = 24'h800000;
          2: off = 24'h7FFFFF;
          3: off = OFFSET_BITS'(int'($urandom_range(2000)) - 1000);
          default: off = OFFSET_BITS'($urandom);
        endcase
      end
    endcase

    // place segments so that frame = effective + offset stays in range
    lower  = -longint'($signed(off));
    if (lower < 0) lower = 0;
    cursor = lower + $urandom_range(3000);
    n_segs = ($urandom_range(7) == 0) ? $urandom_range(60, 13) : $urandom_range(12);
    ep_lo.delete();
    ep_hi.delete();
    for (int i = 0; i < n_segs; i++) begin
      lo     = cursor + (($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1));
      hi     = lo + $urandom_range(8);
      cursor = hi;
      ep_lo.insert(ep_lo.size(), FRAME_BITS'(lo));
      ep_hi.insert(ep_hi.size(), FRAME_BITS'(hi));
    end
    // occasionally an inverted or out-of-order segment
    if (n_segs > 0 && $urandom_range(9) == 0) begin
      k = $urandom_range(n_segs - 1);
      if ($urandom_range(1)) begin
        lo = ep_lo[k];
        ep_lo[k] = ep_hi[k];
        ep_hi[k] = FRAME_BITS'(lo);
      end else begin
        ep_hi[k] = FRAME_BITS'($urandom_range(2000));
      end
    end

    case (ep)
      0:       begin rf = '1;                     rt = '1;                      end
      1:       begin rf = '0;                     rt = RANGE_BITS'(24'hFFFFFF); end
      2:       begin rf = RANGE_BITS'(24'hFFFFFF); rt = '1;                      end
      3:       begin rf = 25'h1000000;            rt = 25'h1FFFFFE;             end
      default: begin rf = random_range_reg(1'b0); rt = random_range_reg(1'b1);  end
    endcase

    wait_results_drained();
    cfg_write(CFG_FRAME_OFFSET, {1'($urandom_range(1)), off});
    cfg_write(CFG_RANGE_FROM, rf);
    cfg_write(CFG_RANGE_TO, rt);
    if (ep == 0 || $urandom_range(15) == 0) cfg_write(CFG_SPARE, CFG_DATA_BITS'($urandom));
    settings_used++;

    // mostly a fresh table; sometimes the new segments append to the old one
    r = random_request();
    r.cmd = CMD_CLEAR;
    if ($urandom_range(9) != 0) send_request(r);
    for (int i = 0; i < n_segs; i++) begin
      r = random_request();
      r.cmd       = CMD_LOAD;
      r.seg_begin = ep_lo[i];
      r.seg_end   = ep_hi[i];
      send_request(r);
    end

    if (ep % 16 == 7) hold_asked++;
    n_q = $urandom_range(18, 6);
    repeat (n_q) begin
      r   = random_request();
      sel = $urandom_range(19);
      if (sel < 11) begin
        r.cmd     = CMD_BLANK;
        r.frame_a = pick_frame();
      end else if (sel < 18) begin
        r.cmd     = CMD_PAIR;
        r.frame_a = pick_frame();
        case ($urandom_range(2))
          0:       r.frame_b = r.frame_a;
          1:       r.frame_b = r.frame_a + FRAME_BITS'(1);
          default: r.frame_b = pick_frame();
        endcase
      end
      // else: leave as a fully random request
      send_request(r);
    end
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.table_full) full_seen++;
      if (verdict_q.size() == 0) begin
        report_mismatch("result with no request pending, verdict", out_data.verdict, -1);
      end else begin
        want = verdict_q.pop_front();
        if (out_data.verdict !== want.verdict)
          report_mismatch("verdict", out_data.verdict, want.verdict);
        if (out_data.table_full !== want.table_full)
          report_mismatch("table_full", out_data.table_full, want.table_full);
      end
    end
  end

  initial begin : watchdog
    #1600000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int start, ep, done, directed_cnt;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    tbl_count = 0;
    m_offset  = '0;
    m_from    = '1;
    m_to      = '1;

    // empty table, then a small ordered table queried across its edges
    add_row(mk_row(CMD_BLANK, 0,         0,         0, 1, V_BLANK));
    add_row(mk_row(CMD_PAIR,  24'hFFFFFF, 0,        0, 1, V_IDENTICAL));
    add_row(mk_row(CMD_LOAD,  10, 20, 0, 1));
    add_row(mk_row(CMD_LOAD,  20, 30, 1, 1));
    add_row(mk_row(CMD_LOAD,  40, 50, 0, 1));
    add_row(mk_row(CMD_LOAD,  50, 50, 1, 1));
    add_row(mk_row(CMD_LOAD,  60, 70, 1, 1));
    add_row(mk_row(CMD_BLANK, 15, 0,  0, 1, V_STATIC));
    add_row(mk_row(CMD_BLANK, 25, 0,  0, 1, V_ANIMATED));
    add_row(mk_row(CMD_BLANK, 35, 0,  0, 1, V_BLANK));
    add_row(mk_row(CMD_BLANK, 9,  0,  0, 1, V_BLANK));
    add_row(mk_row(CMD_BLANK, 70, 0,  0, 1, V_BLANK));
    add_row(mk_row(CMD_BLANK, 69, 0,  0));
    add_row(mk_row(CMD_BLANK, 50, 0,  0));
    add_row(mk_row(CMD_PAIR,  15, 16, 0, 1, V_IDENTICAL));
    add_row(mk_row(CMD_PAIR,  15, 45, 0, 1, V_UNDETERMINED));
    add_row(mk_row(CMD_PAIR,  15, 35, 0, 1, V_DIFFERENT));
    add_row(mk_row(CMD_PAIR,  35, 36, 0, 1, V_IDENTICAL));
    add_row(mk_row(CMD_PAIR,  5,  25, 0));
    add_row(mk_row(CMD_PAIR,  15, 24'hFFFFFF, 0));
    add_row(mk_row(CMD_PAIR,  25, 25, 0));
    // inverted segment stored as given
    add_row(mk_row(CMD_LOAD,  90, 80, 1));
    add_row(mk_row(CMD_BLANK, 85, 0,  0));
    add_row(mk_row(CMD_CLEAR, 0,  0,  0, 1));
    add_row(mk_row(CMD_BLANK, 15, 0,  0, 1, V_BLANK));

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_request(plan[i].req, plan[i].typed, plan[i].want);
    directed_cnt = requests_sent;

    start = requests_sent;
    ep    = 0;
    while (requests_sent - start < RANDOM_REQUESTS) begin
      done = requests_sent - start;
      if (done < RANDOM_REQUESTS / 3) begin
        in_idle_pct  = 13;
        out_idle_pct = 58;
      end else if (done < 2 * RANDOM_REQUESTS / 3) begin
        in_idle_pct  = 58;
        out_idle_pct = 13;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      run_episode(ep);
      ep++;
    end
    wait_results_drained();

    $display("Covered %0d requests: %0d directed, %0d random over %0d episodes",
             requests_sent, directed_cnt, requests_sent - start, ep);
    $display("%0d results checked, %0d table-full refusals, %0d offset/range settings",
             results_seen, full_seen, settings_used);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/fsc_pkg.sv
rtl/core/fsc_ram.sv
rtl/core/fsc_search_cell.sv
rtl/core/frame_segment_classifier.sv
verif/tb.sv
